### design/lpsw_pkg.sv
package lpsw_pkg;

   // one pixel write transaction
   typedef struct packed {
      logic [6:0] column;
      logic [6:0] row;
      logic       colour;
   } req_type;

   // one controller word
   typedef struct packed {
      logic       is_data;
      logic [7:0] word_byte;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic load;
      logic read;
      logic update;
      logic emit_step;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic req_in_range;
      logic word_last;
   } status_type;

   // word order within one transaction
   typedef enum logic [1:0] {
      WORD_PAGE,
      WORD_COL_LOW,
      WORD_COL_HIGH,
      WORD_DATA
   } word_type;

   localparam logic [7:0] CMD_PAGE     = 8'hB0;
   localparam logic [7:0] NIBBLE_MASK  = 8'h0F;
   localparam logic [7:0] CMD_COL_HIGH = 8'h10;
   localparam logic [7:0] COL_HIGH_MASK = 8'h07;

endpackage

### design/lcd_pixel_shadow_writer_core.sv
// pixel writer for a page addressed lcd: each request transaction names a
// column, a row and a colour; the matching bit of the shadow page byte is set
// or cleared and four controller words go out on the rsp channel (page
// command, column low command, column high command, then the updated page
// byte as data with last set). requests with a column of COLUMNS or more, or
// a row of PAGES*8 or more, are dropped with no output and no store change.
// after reset the shadow store is swept to zero, one byte per cycle, over all
// COLUMNS*PAGES bytes (864 at the defaults); req_ready stays low until the
// sweep is done. a write then runs through accept, store read,
// read-modify-write, and four words at one per cycle while rsp_ready is high;
// a dropped request ends at acceptance. the steps follow from the single
// port store's registered read and the one word per cycle output.
module lcd_pixel_shadow_writer_core #(
   parameter int COLUMNS = 96,
   parameter int PAGES   = 9
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lpsw_pkg::req_type   req,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lpsw_pkg::rsp_type   rsp
);

   lpsw_pkg::cmd_type    cmd;
   lpsw_pkg::status_type status;

   // sequencing: clear sweep, idle, read, update, emit
   lpsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // shadow store, captured request and word formatting
   lpsw_dp #(
      .COLUMNS (COLUMNS),
      .PAGES   (PAGES)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .rsp    (rsp),
      .cmd    (cmd),
      .status (status)
   );

endmodule

### design/lpsw_ctrl.sv
module lpsw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  lpsw_pkg::status_type   status,
   output lpsw_pkg::cmd_type      cmd
);

   lpsw_pkg::state_type state_ff;
   lpsw_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpsw_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lpsw_pkg::ST_CLEAR: begin
            if (status.clear_done) state_in = lpsw_pkg::ST_IDLE;
         end
         lpsw_pkg::ST_IDLE: begin
            if (req_valid && status.req_in_range) state_in = lpsw_pkg::ST_READ;
         end
         lpsw_pkg::ST_READ: begin
            state_in = lpsw_pkg::ST_UPDATE;
         end
         lpsw_pkg::ST_UPDATE: begin
            state_in = lpsw_pkg::ST_EMIT;
         end
         lpsw_pkg::ST_EMIT: begin
            if (rsp_ready && status.word_last) state_in = lpsw_pkg::ST_IDLE;
         end
         default: begin
            state_in = lpsw_pkg::ST_CLEAR;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         lpsw_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         lpsw_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         lpsw_pkg::ST_READ: begin
            cmd.read = 1'b1;
         end
         lpsw_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         lpsw_pkg::ST_EMIT: begin
            rsp_valid     = 1'b1;
            cmd.emit_step = rsp_ready;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### design/lpsw_dp.sv
module lpsw_dp #(
   parameter int COLUMNS = 96,
   parameter int PAGES   = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lpsw_pkg::req_type      req,
   output lpsw_pkg::rsp_type      rsp,
   input  lpsw_pkg::cmd_type      cmd,
   output lpsw_pkg::status_type   status
);

   localparam int DEPTH  = COLUMNS * PAGES;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [7:0] COL_LIMIT = 8'(COLUMNS);
   localparam logic [7:0] ROW_LIMIT = 8'(PAGES * 8);

   logic [7:0]        mem [DEPTH];
   logic [ADDR_W-1:0] clear_cnt_ff, clear_cnt_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [6:0]        column_ff;
   logic [6:0]        row_ff;
   logic              colour_ff;
   logic [7:0]        rd_ff;
   logic [7:0]        byte_ff, byte_in;
   logic [1:0]        word_ff, word_in;
   logic [ADDR_W-1:0] mem_addr;
   logic              mem_we;
   logic [7:0]        mem_wdata;
   logic [7:0]        bit_mask;
   logic [3:0]        page;

   assign page = row_ff[6:3];

   assign status.req_in_range = ({1'b0, req.column} < COL_LIMIT) &&
                                ({1'b0, req.row} < ROW_LIMIT);
   assign status.clear_done   = (clear_cnt_ff == ADDR_W'(DEPTH - 1));
   assign status.word_last    = (word_ff == lpsw_pkg::WORD_DATA);

   // store index is column * PAGES + page
   assign addr_in = ADDR_W'(req.column * PAGES + (req.row >> 3));

   assign bit_mask = 8'b1 << row_ff[2:0];
   assign byte_in  = colour_ff ? (rd_ff | bit_mask) : (rd_ff & ~bit_mask);

   assign mem_addr  = cmd.clear_step ? clear_cnt_ff : addr_ff;
   assign mem_we    = cmd.clear_step || cmd.update;
   assign mem_wdata = cmd.clear_step ? 8'h00 : byte_in;

   assign clear_cnt_in = clear_cnt_ff + ADDR_W'(1);
   assign word_in      = cmd.load ? 2'd0 : word_ff + 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
         word_ff      <= '0;
      end else begin
         if (cmd.clear_step && !status.clear_done) clear_cnt_ff <= clear_cnt_in;
         if (cmd.load || cmd.emit_step) word_ff <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff   <= addr_in;
         column_ff <= req.column;
         row_ff    <= req.row;
         colour_ff <= req.colour;
      end
      if (cmd.update) byte_ff <= byte_in;
   end

   // single port store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      if (cmd.read) rd_ff <= mem[mem_addr];
   end

   always_comb begin
      rsp = '0;
      case (word_ff)
         lpsw_pkg::WORD_PAGE: begin
            rsp.word_byte = lpsw_pkg::CMD_PAGE | ({4'b0, page} & lpsw_pkg::NIBBLE_MASK);
         end
         lpsw_pkg::WORD_COL_LOW: begin
            rsp.word_byte = {1'b0, column_ff} & lpsw_pkg::NIBBLE_MASK;
         end
         lpsw_pkg::WORD_COL_HIGH: begin
            rsp.word_byte = lpsw_pkg::CMD_COL_HIGH |
                            ({5'b0, column_ff[6:4]} & lpsw_pkg::COL_HIGH_MASK);
         end
         lpsw_pkg::WORD_DATA: begin
            rsp.is_data   = 1'b1;
            rsp.word_byte = byte_ff;
            rsp.last      = 1'b1;
         end
         default: begin
            rsp = '0;
         end
      endcase
   end

endmodule

### design/lpsw_checker.sv
module lpsw_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input lpsw_pkg::rsp_type   rsp
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("rsp changed while stalled");

   // only the data word closes a transaction
   a_last_is_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.is_data == rsp.last))
      else $error("last and is_data disagree");

   // no new request while words are pending
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("request taken while output busy");

   // output goes quiet after the last word
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp.last |=> !rsp_valid)
      else $error("word after last");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("activity after reset");

endmodule

bind lcd_pixel_shadow_writer_core lpsw_checker u_lpsw_checker (.*);
